// ===== hw/rtl/fnvh_pkg.sv =====
// Shared types and constants for the FNV-1a 64-bit bucket hash block.
`timescale 1ns / 1ps
`default_nettype none
package fnvh_pkg;

    localparam int unsigned FNVH_HASH_BITS     = 64;
    localparam int unsigned FNVH_BYTE_BITS     = 8;
    localparam int unsigned FNVH_COUNT_BITS    = 17;
    localparam int unsigned FNVH_INDEX_BITS    = 16;
    localparam int unsigned FNVH_BUCKET_BITS_DEF = 16;

    localparam logic [FNVH_HASH_BITS-1:0]  FNVH_BASIS       = 64'hcbf29ce484222325;
    localparam logic [FNVH_COUNT_BITS-1:0] FNVH_COUNT_RESET = 17'd1024;

    // The prime 0x100000001b3 has bits 0, 1, 4, 5, 7, 8 and 40 set, so the
    // product is the sum of the multiplicand shifted by each of these amounts.
    localparam int unsigned FNVH_MUL_STEPS = 7;
    localparam int unsigned FNVH_STEP_BITS = $clog2(FNVH_MUL_STEPS);
    localparam int unsigned FNVH_SHIFT_BITS = 6;
    localparam logic [FNVH_SHIFT_BITS-1:0] FNVH_MUL_SHIFT [FNVH_MUL_STEPS] = '{
        6'd0, 6'd1, 6'd4, 6'd5, 6'd7, 6'd8, 6'd40
    };

    // Restoring remainder takes one dividend bit per cycle.
    localparam int unsigned FNVH_DIV_STEPS = FNVH_HASH_BITS;
    localparam int unsigned FNVH_DIV_CNT_BITS = $clog2(FNVH_DIV_STEPS);

    typedef struct packed {
        logic [FNVH_BYTE_BITS-1:0] key_byte;
        logic                      last_byte;
    } in_t;

    typedef struct packed {
        logic [FNVH_HASH_BITS-1:0]  hash_value;
        logic [FNVH_INDEX_BITS-1:0] bucket_index;
    } out_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fnvh_mod_unit.sv =====
// Iterative restoring remainder of a 64-bit hash by a 17-bit divisor.
`timescale 1ns / 1ps
`default_nettype none
module fnvh_mod_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic [fnvh_pkg::FNVH_HASH_BITS-1:0]  dividend,
    input  wire logic [fnvh_pkg::FNVH_COUNT_BITS-1:0] divisor,
    output logic                                      busy,
    output logic                                      done,
    output logic [fnvh_pkg::FNVH_COUNT_BITS-1:0]      remainder
);

    localparam int unsigned CB = fnvh_pkg::FNVH_COUNT_BITS;
    localparam logic [fnvh_pkg::FNVH_DIV_CNT_BITS-1:0] CNT_LAST =
        fnvh_pkg::FNVH_DIV_CNT_BITS'(fnvh_pkg::FNVH_DIV_STEPS - 1);

    logic [fnvh_pkg::FNVH_HASH_BITS-1:0]    dvd_reg, dvd_next;
    logic [CB-1:0]                          dsr_reg, dsr_next;
    logic [CB-1:0]                          rem_reg, rem_next;
    logic [fnvh_pkg::FNVH_DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                                   busy_reg, busy_next;
    logic                                   done_reg, done_next;
    logic [CB:0]                            partial;
    logic [CB+1:0]                          trial;

    always_comb begin
        partial   = {rem_reg, dvd_reg[fnvh_pkg::FNVH_HASH_BITS-1]};
        trial     = {1'b0, partial} - {2'b00, dsr_reg};
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[fnvh_pkg::FNVH_HASH_BITS-2:0], 1'b0};
            rem_next = trial[CB+1] ? partial[CB-1:0] : trial[CB-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/fnv1a64_bucket_hash.sv =====
// Top level of the FNV-1a 64-bit hash with bucket index.
// A key byte is accepted in the idle state, then takes 7 shift-add steps of the shared adder.
// The last byte of a key then runs the bit-serial remainder, and the output state loads
// the result register once the previous result has been taken.
// The result register frees the input side: the next key starts while a result waits.
// Synchronous active-low reset clears the sequencer, loads the offset basis and sets 1024 buckets.
`timescale 1ns / 1ps
`default_nettype none
module fnv1a64_bucket_hash #(
    parameter int unsigned BUCKET_INDEX_BITS = fnvh_pkg::FNVH_BUCKET_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire fnvh_pkg::in_t                        s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output fnvh_pkg::out_t                            m_data,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [fnvh_pkg::FNVH_COUNT_BITS-1:0] cfg_data
);

    localparam int unsigned HB = fnvh_pkg::FNVH_HASH_BITS;
    localparam int unsigned CB = fnvh_pkg::FNVH_COUNT_BITS;
    localparam int unsigned IB = fnvh_pkg::FNVH_INDEX_BITS;
    localparam int unsigned SB = fnvh_pkg::FNVH_STEP_BITS;

    // The divisor saturates at 2^BUCKET_INDEX_BITS; the index keeps that many bits.
    localparam logic [32:0] BUCKET_LIMIT = 33'd1 << BUCKET_INDEX_BITS;
    localparam logic [32:0] INDEX_MASK   = BUCKET_LIMIT - 33'd1;
    localparam logic [SB-1:0] STEP_LAST  = SB'(fnvh_pkg::FNVH_MUL_STEPS - 1);

    // Sequencer codes.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_MOD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [SB-1:0]     step_reg, step_next;
    logic [HB-1:0]     run_reg, run_next;    // running hash between bytes
    logic [HB-1:0]     mcand_reg, mcand_next; // running hash XOR key byte
    logic [HB-1:0]     acc_reg, acc_next;     // partial product, then finished hash
    logic              last_reg, last_next;
    logic [CB-1:0]     count_reg;
    fnvh_pkg::out_t    out_reg, out_next;
    logic              mvalid_reg, mvalid_next;

    logic [HB-1:0]     shifted;
    logic [HB-1:0]     sum;
    logic [CB-1:0]     divisor;
    logic              mod_start;
    logic              mod_busy;
    logic              mod_done;
    logic [CB-1:0]     mod_rem;
    logic              in_fire;
    logic              out_free;

    // The shared unit: one 64-bit adder fed by a shifter with seven fixed amounts.
    assign shifted = mcand_reg << fnvh_pkg::FNVH_MUL_SHIFT[step_reg];
    assign sum     = acc_reg + shifted;

    // A zero count divides by one; a count beyond the limit saturates to it.
    always_comb begin
        if (count_reg == '0) begin
            divisor = CB'(1);
        end else if ({16'd0, count_reg} > BUCKET_LIMIT) begin
            divisor = BUCKET_LIMIT[CB-1:0];
        end else begin
            divisor = count_reg;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !mvalid_reg || m_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        run_next    = run_reg;
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        last_next   = last_reg;
        out_next    = out_reg;
        mvalid_next = mvalid_reg;
        mod_start   = 1'b0;

        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    mcand_next = run_reg ^ {{(HB-8){1'b0}}, s_data.key_byte};
                    acc_next   = '0;
                    step_next  = '0;
                    last_next  = s_data.last_byte;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                acc_next  = sum;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    if (last_reg) begin
                        run_next   = fnvh_pkg::FNVH_BASIS;
                        mod_start  = 1'b1;
                        state_next = ST_MOD;
                    end else begin
                        run_next   = sum;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_next.hash_value   = acc_reg;
                    out_next.bucket_index = mod_rem[IB-1:0] & INDEX_MASK[IB-1:0];
                    mvalid_next           = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            run_reg    <= fnvh_pkg::FNVH_BASIS;
            count_reg  <= fnvh_pkg::FNVH_COUNT_RESET;
            mvalid_reg <= 1'b0;
            last_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            run_reg    <= run_next;
            mvalid_reg <= mvalid_next;
            last_reg   <= last_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
        end
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
        out_reg   <= out_next;
    end

    fnvh_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (sum),
        .divisor   (divisor),
        .busy      (mod_busy),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign m_valid = mvalid_reg;
    assign m_data  = out_reg;

    // The remainder unit only runs while the sequencer waits on it.
    a_busy_in_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_busy |-> (state_reg == ST_MOD))
        else $error("remainder unit busy outside the remainder phase");

    a_done_in_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> (state_reg == ST_MOD))
        else $error("remainder finished outside the remainder phase");

    // A new request is only presented out of the result-loading state.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised without a finished key");

    // After the last byte of a key the running hash is back at the offset basis.
    a_basis_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOD) |-> (run_reg == fnvh_pkg::FNVH_BASIS))
        else $error("running hash not reloaded at end of key");

    // The bucket index always lies below the effective divisor.
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (mod_rem < divisor))
        else $error("remainder not below divisor");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the FNV-1a 64-bit bucket hash block.
`timescale 1ns / 1ps
module testbench;

    localparam int unsigned HB = fnvh_pkg::FNVH_HASH_BITS;
    localparam int unsigned BB = fnvh_pkg::FNVH_BYTE_BITS;
    localparam int unsigned CB = fnvh_pkg::FNVH_COUNT_BITS;
    localparam int unsigned IB = fnvh_pkg::FNVH_INDEX_BITS;

    localparam logic [HB-1:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_ITEMS = 550;
    localparam int CALM_AFTER = 470;
    localparam int SQUEEZE_CYCLES = 400;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } row_kind_t;

    // One line of the directed stimulus. A configuration row carries only the
    // bucket count; a byte row may carry hash or index values known by hand.
    typedef struct packed {
        row_kind_t          kind;
        logic [CB-1:0]      count;
        logic [BB-1:0]      key_byte;
        logic               last_byte;
        logic               hash_known;
        logic [HB-1:0]      hash;
        logic               index_known;
        logic [IB-1:0]      index;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 28;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Single zero byte and single 'a' straight out of reset, 1024 buckets.
        '{ROW_BYTE, 17'h0, 8'h00, 1'b1, 1'b1, 64'haf63bd4c8601b7df, 1'b1, 16'h03df},
        '{ROW_BYTE, 17'h0, 8'h61, 1'b1, 1'b1, 64'haf63dc4c8601ec8c, 1'b1, 16'h008c},
        // A short key with extreme byte values.
        '{ROW_BYTE, 17'h0, 8'hff, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h00, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h80, 1'b1, 1'b0, 64'h0, 1'b0, 16'h0},
        // A zero bucket count divides by one.
        '{ROW_CFG,  17'h0, 8'h00, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h00, 1'b1, 1'b1, 64'haf63bd4c8601b7df, 1'b1, 16'h0000},
        '{ROW_CFG,  17'h1, 8'h00, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h61, 1'b1, 1'b1, 64'haf63dc4c8601ec8c, 1'b1, 16'h0000},
        // Counts above 65536 saturate, so from 65536 up the index is the low 16 hash bits; 65535 follows.
        '{ROW_CFG,  17'h1ffff, 8'h00, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h00, 1'b1, 1'b1, 64'haf63bd4c8601b7df, 1'b1, 16'hb7df},
        '{ROW_CFG,  17'h10000, 8'h00, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h61, 1'b1, 1'b1, 64'haf63dc4c8601ec8c, 1'b1, 16'hec8c},
        '{ROW_CFG,  17'h10001, 8'h00, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'hff, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'hff, 1'b1, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_CFG,  17'h0ffff, 8'h00, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h55, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'haa, 1'b1, 1'b0, 64'h0, 1'b0, 16'h0},
        // A walking one through an eight-byte key with a small odd divisor.
        '{ROW_CFG,  17'h7, 8'h00, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h01, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h02, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h04, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h08, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h10, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h20, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h40, 1'b0, 1'b0, 64'h0, 1'b0, 16'h0},
        '{ROW_BYTE, 17'h0, 8'h80, 1'b1, 1'b0, 64'h0, 1'b0, 16'h0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    fnvh_pkg::in_t        s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    fnvh_pkg::out_t       m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CB-1:0]        cfg_data = '0;

    // Shadow state of the block: the running hash and the bucket count register.
    logic [HB-1:0]        run_hash = fnvh_pkg::FNVH_BASIS;
    logic [CB-1:0]        bucket_setting = fnvh_pkg::FNVH_COUNT_RESET;
    fnvh_pkg::out_t       pending_hashes [$];

    int failures = 0;
    // When set, the result side stops its random stalls for the last part of the run.
    bit calm = 1'b0;
    // Raised by the stimulus to ask the result side for one long hold-off.
    bit squeeze_req = 1'b0;

    fnv1a64_bucket_hash u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // The divisor that the bucket count stands for: zero counts as one bucket,
    // and anything beyond the index range is clamped to the full index range.
    function automatic logic [HB-1:0] bucket_divisor(
        input logic [CB-1:0] count
    );
        logic [HB-1:0] limit;
        limit = 64'd1 << fnvh_pkg::FNVH_BUCKET_BITS_DEF;
        if (count == '0) begin
            return 64'd1;
        end else if (64'(count) > limit) begin
            return limit;
        end
        return 64'(count);
    endfunction

    // Folds one accepted byte into the shadow hash. The last byte of a key
    // produces the expected result and restarts from the offset basis.
    function automatic void fold_byte(input fnvh_pkg::in_t item);
        logic [HB-1:0]  next_hash;
        fnvh_pkg::out_t result;
        next_hash = (run_hash ^ 64'(item.key_byte)) * FNV_PRIME;
        if (!item.last_byte) begin
            run_hash = next_hash;
        end else begin
            result.hash_value   = next_hash;
            result.bucket_index = IB'(next_hash % bucket_divisor(bucket_setting));
            pending_hashes.push_back(result);
            run_hash = fnvh_pkg::FNVH_BASIS;
        end
    endfunction

    // Offers one key byte, sometimes after a short gap, and waits until the
    // block takes it. Valid stays high afterwards until a later gap or drain lowers it.
    task automatic push_byte(input logic [BB-1:0] key_byte, input logic last_byte);
        fnvh_pkg::in_t item;
        int            gap;
        item.key_byte  = key_byte;
        item.last_byte = last_byte;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        fold_byte(item);
    endtask

    // Drops the request line and waits until every key has come back, then
    // lets the block settle before the caller touches the register.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_buckets(input logic [CB-1:0] count);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        bucket_setting = count;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CB-1:0] pick_bucket_count();
        unique case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return 17'd1;
            end
            2: begin
                return 17'h10000;
            end
            3: begin
                return 17'h1ffff;
            end
            4: begin
                return 17'h0ffff;
            end
            5: begin
                return CB'($urandom_range(2, 16));
            end
            6: begin
                return CB'($urandom);
            end
            default: begin
                return CB'($urandom_range(1, 65536));
            end
        endcase
    endfunction

    // Result side: checks every returned request against the oldest expected
    // hash and drives ready with random stall bursts, plus long hold-offs on demand.
    initial begin : result_side
        int             stall_left;
        fnvh_pkg::out_t want;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_hashes.size() == 0) begin
                    $error("unexpected result: hash_value %h bucket_index %h",
                        m_data.hash_value, m_data.bucket_index);
                    failures++;
                end else begin
                    want = pending_hashes.pop_front();
                    if (m_data.hash_value !== want.hash_value) begin
                        $error("hash_value: expected %h, got %h",
                            want.hash_value, m_data.hash_value);
                        failures++;
                    end
                    if (m_data.bucket_index !== want.bucket_index) begin
                        $error("bucket_index: expected %h, got %h",
                            want.bucket_index, m_data.bucket_index);
                        failures++;
                    end
                end
            end
            @(negedge aclk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                stall_left = SQUEEZE_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int  random_items;
        int  phase;
        int  key_count;
        int  key_len;
        bit  squeeze_phase;
        random_items = 0;
        phase = 0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. Rows with hand-known values overwrite the prediction
        // so that the block gets checked against the hand-known values on those keys.
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                wait_drained();
                write_buckets(DIRECTED[i].count);
            end else begin
                push_byte(DIRECTED[i].key_byte, DIRECTED[i].last_byte);
                if (DIRECTED[i].last_byte && DIRECTED[i].hash_known) begin
                    pending_hashes[pending_hashes.size() - 1].hash_value = DIRECTED[i].hash;
                end
                if (DIRECTED[i].last_byte && DIRECTED[i].index_known) begin
                    pending_hashes[pending_hashes.size() - 1].bucket_index = DIRECTED[i].index;
                end
            end
        end

        // Random part: each phase sets a new bucket count and then streams
        // keys of random length, mostly short, with an occasional long one.
        // No new key starts once the item budget is spent.
        while (random_items < RANDOM_ITEMS) begin
            wait_drained();
            write_buckets(pick_bucket_count());
            squeeze_phase = (phase == 2 || phase == 7);
            key_count = squeeze_phase ? 14 : $urandom_range(5, 20);
            for (int k = 0; k < key_count && random_items < RANDOM_ITEMS; k++) begin
                // Keep offering keys while the result side is held off, so the
                // result register fills and the block has to stall its input.
                if (squeeze_phase && k == 2 && !calm) begin
                    squeeze_req = 1'b1;
                end
                key_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24)
                                                      : $urandom_range(1, 6);
                for (int b = 0; b < key_len; b++) begin
                    push_byte(BB'($urandom), b == key_len - 1);
                    random_items++;
                    calm = (random_items >= CALM_AFTER);
                end
            end
            phase++;
        end

        wait_drained();
        if (failures == 0 && pending_hashes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== fnv1a64_bucket_hash.f =====
hw/rtl/fnvh_pkg.sv
hw/rtl/fnvh_mod_unit.sv
hw/rtl/fnv1a64_bucket_hash.sv
tb/sv/testbench.sv
